// ===== design/kbsa_pkg.sv =====
// ----------------------------------------------------------------------------
// kbsa_pkg
// Shared types and constants for the kB stack allocator.
// ----------------------------------------------------------------------------
package kbsa_pkg;

    // field widths of the request and result ports
    localparam int FIELD_KB_W = 10;
    localparam int SIZE_B_W   = 20;
    localparam int MARK_W     = 11;
    // wide enough for boundary plus one mark (up to 2048)
    localparam int SUM_W      = 12;

    // register reset and register map
    localparam logic [FIELD_KB_W-1:0] START_FREE_RESET = 10'd640;
    localparam logic                  REG_START_FREE   = 1'b0;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_EV
    } kbsa_state_t;

    // register load towards the allocator core
    typedef struct packed {
        logic                  load;
        logic [FIELD_KB_W-1:0] value;
    } kbsa_cfg_t;

    // bytes to whole kB, rounded up
    function automatic logic [MARK_W-1:0] kbsa_round_kb(input logic [SIZE_B_W-1:0] bytes);
        logic [SIZE_B_W:0] sum;
        sum = {1'b0, bytes} + (SIZE_B_W+1)'(1023);
        return sum[SIZE_B_W:10];
    endfunction

endpackage

// ===== design/kbsa_mark_ram.sv =====
// ----------------------------------------------------------------------------
// kbsa_mark_ram
// Mark table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kbsa_mark_ram
    import kbsa_pkg::*;
#(
    parameter int DEPTH = 640,
    parameter int AW    = 10
)
(
    input  logic              clk,
    input  logic              wen,
    input  logic [AW-1:0]     waddr,
    input  logic [MARK_W-1:0] wdata,
    input  logic              ren,
    input  logic [AW-1:0]     raddr,
    output logic [MARK_W-1:0] rdata
);

    logic [MARK_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/kbsa_apb_regs.sv =====
// ----------------------------------------------------------------------------
// kbsa_apb_regs
// APB register slave holding start_free_kb.
// ----------------------------------------------------------------------------
module kbsa_apb_regs
    import kbsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output kbsa_cfg_t             cfg
);

    logic                  wr_hit;
    logic [FIELD_KB_W-1:0] start_free_reg;
    logic [FIELD_KB_W-1:0] start_free_next;

    // word index is paddr[2]; only index 0 exists
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_START_FREE);

    assign start_free_next = wr_hit ? pwdata[FIELD_KB_W-1:0] : start_free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_free_reg <= START_FREE_RESET;
        end
        else
        begin
            start_free_reg <= start_free_next;
        end
    end

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_START_FREE)
                       ? {{(APB_DATA_W-FIELD_KB_W){1'b0}}, start_free_reg}
                       : '0;
    assign cfg.load  = wr_hit;
    assign cfg.value = pwdata[FIELD_KB_W-1:0];

endmodule

// ===== design/kb_stack_allocator_deferred_free.sv =====
// ----------------------------------------------------------------------------
// kb_stack_allocator_deferred_free
// kB stack allocator growing down from the region top, with deferred frees.
// ----------------------------------------------------------------------------
// Usage: issue a request by raising start while busy is low. The result comes
// back on ok/address_kb/free_kb for exactly one cycle, flagged by done; there
// is no back-pressure, so the receiver must take it then. Allocates, ignored
// frees, frees that do not sit on the free boundary, and boundary frees whose
// own block takes the boundary to the region top all answer on the cycle after
// the request and leave busy low, so one request per cycle is possible. Any
// other free landing on the boundary walks the mark table. Its own block is
// returned in the accept cycle, then each further mark takes a memory read
// state and an evaluate-and-clear state, since the mark RAM's read data is
// registered. The walk answers when it stops on an unmarked address or when
// a block takes the boundary to the region top. After reset, and after every
// write of start_free_kb, busy stays high while the mark RAM is cleared one
// entry per cycle.
// ----------------------------------------------------------------------------
module kb_stack_allocator_deferred_free
    import kbsa_pkg::*;
#(
    parameter int TOTAL_KB = 640
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request
    input  logic                  start,
    output logic                  busy,
    input  logic                  mode,
    input  logic [SIZE_B_W-1:0]   size_bytes,
    input  logic [FIELD_KB_W-1:0] block_address_kb,
    // result
    output logic                  done,
    output logic                  ok,
    output logic [FIELD_KB_W-1:0] address_kb,
    output logic [FIELD_KB_W-1:0] free_kb,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(TOTAL_KB);
    localparam int CW = $clog2(TOTAL_KB + 1);
    localparam logic [SUM_W-1:0] TOP      = SUM_W'(TOTAL_KB);
    localparam logic [AW-1:0]    LAST_IDX = AW'(TOTAL_KB - 1);

    kbsa_cfg_t cfg;

    kbsa_state_t state_reg, state_next;

    logic [CW-1:0]         counter_reg, counter_next;
    logic [AW-1:0]         clr_idx_reg, clr_idx_next;
    logic                  done_reg, done_next;
    logic                  ok_reg, ok_next;
    logic [FIELD_KB_W-1:0] addr_reg, addr_next;
    logic [FIELD_KB_W-1:0] free_reg, free_next;

    // mark RAM port signals
    logic              mem_wen;
    logic [AW-1:0]     mem_waddr;
    logic [MARK_W-1:0] mem_wdata;
    logic              mem_ren;
    logic [MARK_W-1:0] mem_rdata;

    // request decode
    logic              accept;
    logic [MARK_W-1:0] size_kb;
    logic [SUM_W-1:0]  cnt_x;
    logic [SUM_W-1:0]  size_x;
    logic [SUM_W-1:0]  addr_x;
    logic [SUM_W-1:0]  alloc_left;
    logic              alloc_fits;
    logic              free_valid;
    logic              free_walk;
    logic [SUM_W-1:0]  step_sum;
    logic [SUM_W-1:0]  step_sat;
    logic [SUM_W-1:0]  walk_sum;
    logic [SUM_W-1:0]  walk_sat;
    logic [SUM_W-1:0]  cfg_sat;
    logic              mark_zero;

    kbsa_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kbsa_mark_ram #(
        .DEPTH (TOTAL_KB),
        .AW    (AW)
    ) u_marks (
        .clk   (clk),
        .wen   (mem_wen),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .ren   (mem_ren),
        .raddr (counter_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign size_kb = kbsa_round_kb(size_bytes);
    assign cnt_x   = SUM_W'(counter_reg);
    assign size_x  = SUM_W'(size_kb);
    assign addr_x  = SUM_W'(block_address_kb);

    assign alloc_fits = (size_x <= cnt_x);
    assign alloc_left = cnt_x - size_x;

    assign free_valid = (size_kb != '0) && (addr_x < TOP);
    // block sits on the boundary: its own mark is the first step of the walk
    assign free_walk  = free_valid && (addr_x == cnt_x);

    assign step_sum = cnt_x + size_x;
    assign step_sat = (step_sum > TOP) ? TOP : step_sum;

    assign mark_zero = (mem_rdata == '0);
    assign walk_sum  = cnt_x + SUM_W'(mem_rdata);
    assign walk_sat  = (walk_sum > TOP) ? TOP : walk_sum;

    assign cfg_sat = (SUM_W'(cfg.value) > TOP) ? TOP : SUM_W'(cfg.value);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && mode && free_walk && (step_sat < TOP))
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD:
            begin
                state_next = ST_WALK_EV;
            end
            ST_WALK_EV:
            begin
                if (mark_zero || (walk_sat == TOP))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WALK_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // a register write restarts the clearing pass
        if (cfg.load)
        begin
            state_next = ST_CLEAR;
        end
    end

    // datapath, memory controls and result
    always_comb
    begin
        counter_next = counter_reg;
        clr_idx_next = clr_idx_reg;
        done_next    = 1'b0;
        ok_next      = ok_reg;
        addr_next    = addr_reg;
        free_next    = free_reg;
        mem_wen      = 1'b0;
        mem_waddr    = counter_reg[AW-1:0];
        mem_wdata    = '0;
        mem_ren      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_wen      = 1'b1;
                mem_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!mode)
                    begin
                        done_next = 1'b1;
                        if (alloc_fits)
                        begin
                            counter_next = CW'(alloc_left);
                            ok_next      = 1'b1;
                            addr_next    = alloc_left[FIELD_KB_W-1:0];
                            free_next    = alloc_left[FIELD_KB_W-1:0];
                        end
                        else
                        begin
                            ok_next   = 1'b0;
                            addr_next = '0;
                            free_next = cnt_x[FIELD_KB_W-1:0];
                        end
                    end
                    else
                    begin
                        ok_next   = free_valid;
                        addr_next = '0;
                        if (free_valid)
                        begin
                            mem_wen   = 1'b1;
                            mem_waddr = block_address_kb[AW-1:0];
                            mem_wdata = free_walk ? '0 : size_kb;
                        end
                        if (free_walk)
                        begin
                            counter_next = CW'(step_sat);
                            // boundary reached the top: nothing left to walk
                            if (step_sat == TOP)
                            begin
                                done_next = 1'b1;
                                free_next = step_sat[FIELD_KB_W-1:0];
                            end
                        end
                        else
                        begin
                            done_next = 1'b1;
                            free_next = cnt_x[FIELD_KB_W-1:0];
                        end
                    end
                end
            end
            ST_WALK_RD:
            begin
                mem_ren = 1'b1;
            end
            ST_WALK_EV:
            begin
                if (mark_zero)
                begin
                    done_next = 1'b1;
                    free_next = cnt_x[FIELD_KB_W-1:0];
                end
                else
                begin
                    mem_wen      = 1'b1;
                    mem_waddr    = counter_reg[AW-1:0];
                    counter_next = CW'(walk_sat);
                    if (walk_sat == TOP)
                    begin
                        done_next = 1'b1;
                        free_next = walk_sat[FIELD_KB_W-1:0];
                    end
                end
            end
            default:
            begin
                counter_next = counter_reg;
            end
        endcase
        if (cfg.load)
        begin
            counter_next = CW'(cfg_sat);
            clr_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            counter_reg <= (SUM_W'(START_FREE_RESET) > TOP) ? CW'(TOP)
                                                            : CW'(START_FREE_RESET);
            clr_idx_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
            clr_idx_reg <= clr_idx_next;
            done_reg    <= done_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        ok_reg   <= ok_next;
        addr_reg <= addr_next;
        free_reg <= free_next;
    end

    assign done       = done_reg;
    assign ok         = ok_reg;
    assign address_kb = addr_reg;
    assign free_kb    = free_reg;

endmodule

// ===== tb/sv/kb_stack_allocator_deferred_free_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kb_stack_allocator_deferred_free_tb
// Self-checking bench for the kB stack allocator with deferred frees.
// Requests go in through the start/busy port and the register through the
// APB port. A behavioural copy of the allocator predicts every answer, and
// each done strobe is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module kb_stack_allocator_deferred_free_tb;
    import kbsa_pkg::*;

    localparam int TOTAL_KB = 640;
    // far above the slowest legal run: gaps, boundary walks and clearing passes
    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned PRINT_CAP   = 40;

    // request opcodes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // start_free_kb is register 0, so it sits at byte address 0
    localparam logic [APB_ADDR_W-1:0] START_FREE_ADDR = APB_ADDR_W'(int'(REG_START_FREE) * 4);

    // one answer of the allocator, as carried by a done strobe
    typedef struct packed {
        logic                  ok;
        logic [FIELD_KB_W-1:0] address;
        logic [FIELD_KB_W-1:0] free;
    } alloc_answer_t;

    // a block handed out and not yet given back, for well-formed frees
    typedef struct packed {
        logic [FIELD_KB_W-1:0] base;
        logic [MARK_W-1:0]     kb;
    } live_block_t;

    // ------------------------------------------------------------------------
    // DUT signals: every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                  clk              = 1'b0;
    logic                  rst_n            = 1'b0;
    logic                  start            = 1'b0;
    logic                  mode             = MODE_ALLOC;
    logic [SIZE_B_W-1:0]   size_bytes       = '0;
    logic [FIELD_KB_W-1:0] block_address_kb = '0;
    logic                  psel             = 1'b0;
    logic                  penable          = 1'b0;
    logic                  pwrite           = 1'b0;
    logic [APB_ADDR_W-1:0] paddr            = '0;
    logic [APB_DATA_W-1:0] pwdata           = '0;
    logic                  busy;
    logic                  done;
    logic                  ok;
    logic [FIELD_KB_W-1:0] address_kb;
    logic [FIELD_KB_W-1:0] free_kb;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    kb_stack_allocator_deferred_free #(
        .TOTAL_KB (TOTAL_KB)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .size_bytes       (size_bytes),
        .block_address_kb (block_address_kb),
        .done             (done),
        .ok               (ok),
        .address_kb       (address_kb),
        .free_kb          (free_kb),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Allocator shadow: register copy, free boundary and mark table
    // ------------------------------------------------------------------------
    logic [FIELD_KB_W-1:0] start_free_reg;
    int unsigned           boundary_kb;
    logic [MARK_W-1:0]     mark_kb [TOTAL_KB];

    // predicted answers in request order, oldest at the front
    alloc_answer_t pending_answers [$];
    live_block_t   live_blocks [$];

    int unsigned sender_idle_pct = 0;
    int unsigned cycle_count     = 0;
    int unsigned n_errors        = 0;
    int unsigned n_requests      = 0;
    int unsigned n_checked       = 0;
    int unsigned n_settings      = 0;
    int unsigned n_refused       = 0;
    int unsigned n_returned      = 0;

    // bytes to kB, rounded up: whole kB plus one if any byte spills over
    function automatic logic [MARK_W-1:0] bytes_to_kb(input logic [SIZE_B_W-1:0] b);
        return {1'b0, b[SIZE_B_W-1:10]} + MARK_W'(b[9:0] != '0);
    endfunction

    // a byte count that rounds to exactly kb kilobytes (kb >= 1)
    function automatic logic [SIZE_B_W-1:0] kb_to_bytes(input logic [MARK_W-1:0] kb);
        return SIZE_B_W'((int'(kb) - 1) * 1024 + int'($urandom_range(1, 1024)));
    endfunction

    // register write: load the boundary (capped at the region top), wipe marks
    function automatic void load_start_free(input logic [FIELD_KB_W-1:0] v);
        start_free_reg = v;
        boundary_kb    = (v > TOTAL_KB) ? TOTAL_KB : v;
        foreach (mark_kb[i])
            mark_kb[i] = '0;
    endfunction

    // one accepted request: update the shadow and return its answer
    function automatic alloc_answer_t predict_request(input logic m,
                                                      input logic [SIZE_B_W-1:0] b,
                                                      input logic [FIELD_KB_W-1:0] where);
        alloc_answer_t     ans;
        logic [MARK_W-1:0] kb;
        logic [MARK_W-1:0] mark;
        kb  = bytes_to_kb(b);
        ans = '0;
        if (m == MODE_ALLOC) begin
            if (kb <= boundary_kb) begin
                boundary_kb = boundary_kb - kb;
                ans.ok      = 1'b1;
                ans.address = FIELD_KB_W'(boundary_kb);
            end else begin
                n_refused++;
            end
        end else if (kb != '0 && where < TOTAL_KB) begin
            ans.ok         = 1'b1;
            mark_kb[where] = kb;
            // block on the boundary: give back consecutive marked blocks
            if (where == boundary_kb) begin
                while (boundary_kb < TOTAL_KB && mark_kb[boundary_kb] != '0) begin
                    mark                 = mark_kb[boundary_kb];
                    mark_kb[boundary_kb] = '0;
                    boundary_kb          = (boundary_kb + mark > TOTAL_KB) ?
                                           TOTAL_KB : boundary_kb + mark;
                    n_returned++;
                end
            end
        end
        ans.free = FIELD_KB_W'(boundary_kb);
        return ans;
    endfunction

    initial load_start_free(START_FREE_RESET);

    // ------------------------------------------------------------------------
    // Reporting and answer checking
    // ------------------------------------------------------------------------
    // prints are capped so a broken block cannot flood the log; all are counted
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= PRINT_CAP)
            $display("tb: mismatch on %s after %0d results: got %0d, expected %0d",
                     what, n_checked, got, want);
    endtask

    always @(posedge clk) begin : answer_check
        alloc_answer_t want;
        if (rst_n === 1'b1 && done === 1'b1) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("result with no request outstanding", 32'(free_kb), 32'd0);
            end else begin
                want = pending_answers.pop_front();
                n_checked++;
                if (ok !== want.ok)
                    report_mismatch("ok", 32'(ok), 32'(want.ok));
                if (address_kb !== want.address)
                    report_mismatch("address_kb", 32'(address_kb), 32'(want.address));
                if (free_kb !== want.free)
                    report_mismatch("free_kb", 32'(free_kb), 32'(want.free));
            end
        end
    end

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_answers.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request and register drivers: drive on falling edges, sample on rising
    // ------------------------------------------------------------------------
    // Sends one request after a random idle gap. start is left high on return,
    // so back-to-back requests go out without start dropping in between; callers that stop sending
    // go through wait_answers_drained, which drops it.
    task automatic issue_request(input logic m, input logic [SIZE_B_W-1:0] b,
                                 input logic [FIELD_KB_W-1:0] where,
                                 output alloc_answer_t ans);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start            <= 1'b1;
        mode             <= m;
        size_bytes       <= b;
        block_address_kb <= where;
        do @(posedge clk); while (busy !== 1'b0);
        ans = predict_request(m, b, where);
        pending_answers.push_back(ans);
        n_requests++;
    endtask

    task automatic wait_answers_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // one APB transfer: setup cycle, then access until pready
    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] a,
                              input logic [APB_DATA_W-1:0] d,
                              output logic [APB_DATA_W-1:0] rd);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_start_free_readback();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, START_FREE_ADDR, '0, rd);
        if (rd !== APB_DATA_W'(start_free_reg))
            report_mismatch("start_free_kb read-back", rd, APB_DATA_W'(start_free_reg));
    endtask

    // Register write with the block idle. Junk in the unused upper data bits
    // must be dropped. The block then clears its marks with busy high, which
    // the next request simply waits out.
    task automatic program_start_free(input logic [FIELD_KB_W-1:0] v);
        logic [APB_DATA_W-1:0] rd;
        wait_answers_drained();
        repeat (4) @(negedge clk);
        apb_access(1'b1, START_FREE_ADDR,
                   {(APB_DATA_W-FIELD_KB_W)'($urandom), v}, rd);
        load_start_free(v);
        live_blocks.delete();
        n_settings++;
        check_start_free_readback();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_state();
        check_start_free_readback();
    endtask

    // Field extremes and every corner of allocate and free, from reset state
    task automatic test_directed_edges();
        alloc_answer_t ans;
        sender_idle_pct = 0;
        issue_request(MODE_ALLOC, 20'd0,       10'd0,    ans); // zero bytes: boundary
        issue_request(MODE_ALLOC, 20'd1,       10'd1023, ans); // 1 byte -> 1 kB
        issue_request(MODE_ALLOC, 20'd1024,    10'd0,    ans); // exactly 1 kB
        issue_request(MODE_ALLOC, 20'd1025,    10'd0,    ans); // rounds to 2 kB
        issue_request(MODE_ALLOC, 20'hFFFFF,   10'd0,    ans); // 1024 kB, too large
        issue_request(MODE_ALLOC, 20'd655360,  10'd0,    ans); // whole region, too large
        issue_request(MODE_FREE,  20'd0,       10'd636,  ans); // zero size: ignored
        issue_request(MODE_FREE,  20'd1024,    10'd1023, ans); // out of range: ignored
        issue_request(MODE_FREE,  20'd1024,    10'd640,  ans); // first address past top
        issue_request(MODE_FREE,  20'd1,       10'd638,  ans); // above boundary: mark only
        issue_request(MODE_FREE,  20'd1024,    10'd639,  ans);
        issue_request(MODE_FREE,  20'd1025,    10'd636,  ans); // on boundary: walk to top
        issue_request(MODE_ALLOC, 20'd10240,   10'd0,    ans);
        issue_request(MODE_FREE,  20'd102400,  10'd630,  ans); // overshoot saturates
        issue_request(MODE_ALLOC, 20'd655360,  10'd0,    ans); // whole region
        issue_request(MODE_ALLOC, 20'd1,       10'd0,    ans); // nothing left
        issue_request(MODE_ALLOC, 20'd0,       10'd0,    ans); // zero bytes at zero
        issue_request(MODE_FREE,  20'd3072,    10'd5,    ans); // mark above boundary
        issue_request(MODE_FREE,  20'd7168,    10'd5,    ans); // overwrite that mark
        issue_request(MODE_FREE,  20'd5120,    10'd0,    ans); // walk 0 -> 5 -> 12
        issue_request(MODE_FREE,  20'hFFFFF,   10'd12,   ans); // widest mark, saturates
    endtask

    // Register extremes: empty region, over-range value, back to full
    task automatic test_register_extremes();
        alloc_answer_t ans;
        sender_idle_pct = 0;
        program_start_free(10'd0);
        issue_request(MODE_ALLOC, 20'd1,      10'd0, ans); // no room at all
        issue_request(MODE_ALLOC, 20'd0,      10'd0, ans);
        issue_request(MODE_FREE,  20'd2048,   10'd0, ans); // boundary climbs from zero
        issue_request(MODE_ALLOC, 20'd2048,   10'd0, ans);
        program_start_free(10'd1023);                      // capped at the region top
        issue_request(MODE_ALLOC, 20'd655360, 10'd0, ans);
    endtask

    function automatic logic [SIZE_B_W-1:0] random_alloc_bytes();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 2)  return '0;
        if (r < 70) return SIZE_B_W'($urandom_range(1, 16384));
        if (r < 90) return SIZE_B_W'($urandom_range(16385, 65536));
        if (r < 98) return SIZE_B_W'($urandom_range(65537, 655360));
        return SIZE_B_W'($urandom);
    endfunction

    function automatic logic [SIZE_B_W-1:0] random_noise_bytes();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return '0;
        if (r < 30) return '1;
        if (r < 60) return SIZE_B_W'($urandom);
        return SIZE_B_W'($urandom_range(1, 8192));
    endfunction

    // Mostly well-formed traffic: allocate, then give blocks back in random
    // order with their true sizes so the boundary walks coalesce runs of
    // freed blocks. The rest frees on the boundary with made-up sizes, or
    // is noise: out-of-range addresses, zero and huge sizes, stray marks.
    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input logic [FIELD_KB_W-1:0] start_kb,
                                       input int unsigned items);
        alloc_answer_t         ans;
        live_block_t           blk;
        int unsigned           roll;
        int unsigned           pick;
        logic                  m;
        logic [SIZE_B_W-1:0]   b;
        logic [FIELD_KB_W-1:0] where;
        program_start_free(start_kb);
        sender_idle_pct = idle_pct;
        for (int unsigned n = 0; n < items; n++) begin
            // hold off now and then until every answer is back
            if (n == items / 2 || $urandom_range(199) == 0)
                wait_answers_drained();
            roll = $urandom_range(99);
            if (roll < 82) begin
                if (live_blocks.size() != 0 &&
                    ($urandom_range(99) < 45 || boundary_kb < 24 || live_blocks.size() >= 96)) begin
                    pick  = $urandom_range(live_blocks.size() - 1);
                    blk   = live_blocks[pick];
                    live_blocks.delete(pick);
                    m     = MODE_FREE;
                    where = blk.base;
                    b     = kb_to_bytes(blk.kb);
                end else begin
                    m     = MODE_ALLOC;
                    b     = random_alloc_bytes();
                    where = FIELD_KB_W'($urandom); // don't-care on allocate
                end
            end else if (roll < 90) begin
                m     = MODE_FREE;
                where = FIELD_KB_W'(boundary_kb);
                b     = SIZE_B_W'($urandom_range(1, 32768));
            end else begin
                m    = 1'($urandom_range(1));
                b    = random_noise_bytes();
                roll = $urandom_range(99);
                if (roll < 40)
                    where = FIELD_KB_W'($urandom_range(TOTAL_KB, 1023));
                else if (roll < 70 || live_blocks.size() == 0)
                    where = FIELD_KB_W'($urandom);
                else
                    where = live_blocks[$urandom_range(live_blocks.size() - 1)].base;
            end
            issue_request(m, b, where, ans);
            if (m == MODE_ALLOC && ans.ok && bytes_to_kb(b) != '0) begin
                blk.base = ans.address;
                blk.kb   = bytes_to_kb(b);
                live_blocks.push_back(blk);
            end
        end
        sender_idle_pct = 0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_directed_edges();
        test_register_extremes();
        // idling patterns: none, sender idle 65 in 100, sender idle 6 in 100
        test_random_traffic(0,  10'd640,  300);
        test_random_traffic(65, 10'd1023, 280);
        test_random_traffic(6,  10'd0,    250);
        test_random_traffic(0,  10'($urandom_range(1, TOTAL_KB - 1)), 300);
        test_random_traffic(65, 10'd640,  250);
        test_random_traffic(6,  10'd300,  300);

        // let any stray strobe show up before judging
        wait_answers_drained();
        repeat (64) @(posedge clk);
        if (pending_answers.size() != 0)
            report_mismatch("results never delivered", pending_answers.size(), 32'd0);

        $display("tb: %0d requests under %0d register settings, %0d results checked",
                 n_requests, n_settings, n_checked);
        $display("tb: %0d allocations refused, %0d marked blocks returned by walks",
                 n_refused, n_returned);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
